>>> sv/xcpf_pkg.sv
// Shared types and constants for the XOR checksum packet framer.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps

package xcpf_pkg;

   // Most bytes that one request can produce.
   localparam int unsigned BurstLen = 5;
   localparam int unsigned IdxW     = $clog2(BurstLen);
   localparam int unsigned ByteW    = 8;

   // Register map: byte address 4*i, so one address bit selects the register.
   localparam int unsigned AddrW = 3;
   localparam int unsigned DataW = 32;

   typedef enum logic [0:0] {
      REG_START_BYTE = 1'b0,
      REG_STOP_BYTE  = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      CMD_HEADER = 1'b0,
      CMD_BODY   = 1'b1
   } cmd_type;

   // Reset values of the marker registers.
   localparam logic [ByteW-1:0] StartByteReset = 8'h02;
   localparam logic [ByteW-1:0] StopByteReset  = 8'h03;

   // Byte burst produced by one request: bytes in send order.
   typedef struct packed {
      logic [BurstLen-1:0][ByteW-1:0] bytes;
      logic [IdxW-1:0]                last_idx;  // index of the final byte
      logic                           trailer;   // burst closes a frame
      logic                           error;     // out-of-order request
   } burst_type;

endpackage

>>> sv/xor_checksum_packet_framer_unit.sv
// Top level of the XOR checksum packet framer: register port, frame
// tracker and byte serializer. Depends on xcpf_pkg, xcpf_frame_ctrl, xcpf_serializer.
`timescale 1ns / 1ps
//
// Usage:
//   Request channel (req_*): cmd 0 is a header (body_length, message_type),
//   cmd 1 is one body byte. A request is taken when req_valid is high and
//   req_stall is low. Result channel (rsp_*): one byte per transfer, in frame
//   order START, SIZE, TYPE, body..., CHECKSUM, STOP.
//   Header: 3 bytes, or 5 when the body is empty. Body: 1 byte, or 3 for the
//   last one. Out-of-order requests give one error byte (value 0).
//   Path: an accepted request is stored in the burst buffer, and its bytes
//   then move one at a time through the output register onto rsp_*.
//   Throughput: one result byte per cycle while rsp_stall is low, set by the
//   single-byte output register; a request occupies the burst buffer until
//   the last of its bytes (1, 3 or 5) moves to the output register, and the
//   next request is taken in the cycle that last byte moves.
//   A stall on rsp_stall holds the output register and, once the burst
//   buffer is full, raises req_stall.
//   Reset (synchronous): no frame open, checksum and count cleared, markers
//   back to 2 and 3, both channels empty.
//   Registers: start_byte at 0x0, stop_byte at 0x4; write only while idle.

module xor_checksum_packet_framer_unit (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [xcpf_pkg::ByteW-1:0]  req_body_length,
   input  logic [xcpf_pkg::ByteW-1:0]  req_message_type,
   input  logic [xcpf_pkg::ByteW-1:0]  req_body_byte,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [xcpf_pkg::ByteW-1:0]  rsp_tx_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_frame_done,
   output logic                        rsp_sequence_error,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [xcpf_pkg::AddrW-1:0]  csr_paddr,
   input  logic [xcpf_pkg::DataW-1:0]  csr_pwdata,
   output logic [xcpf_pkg::DataW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import xcpf_pkg::*;

   logic [ByteW-1:0] start_byte_ff, stop_byte_ff;
   reg_index_type    reg_idx;
   logic             csr_wr, ready, accept, busy;
   burst_type        burst;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= StartByteReset;
         stop_byte_ff  <= StopByteReset;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_START_BYTE: start_byte_ff <= csr_pwdata[ByteW-1:0];
            REG_STOP_BYTE:  stop_byte_ff  <= csr_pwdata[ByteW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_BYTE: csr_prdata = DataW'(start_byte_ff);
         REG_STOP_BYTE:  csr_prdata = DataW'(stop_byte_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Request handshake
   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   xcpf_frame_ctrl u_frame_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .body_length  (req_body_length),
      .message_type (req_message_type),
      .body_byte    (req_body_byte),
      .start_byte   (start_byte_ff),
      .stop_byte    (stop_byte_ff),
      .burst        (burst)
   );

   xcpf_serializer u_serializer (
      .clock              (clock),
      .reset              (reset),
      .load               (accept),
      .burst              (burst),
      .ready              (ready),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_sequence_error (rsp_sequence_error)
   );

`ifndef SYNTHESIS
   // Requests are held back only while a burst is still being sent
   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> busy)
      else $error("req_stall raised with an empty burst buffer");

   // A frame closes only on the final byte of a request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_last_of_run && !rsp_sequence_error))
      else $error("frame_done on a byte that does not end its burst");

   // Error results are single zero bytes
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sequence_error) |-> (rsp_last_of_run && rsp_tx_byte == '0))
      else $error("malformed sequence error result");

   // An accepted request always loads the burst buffer
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not load the burst buffer");
`endif

endmodule

>>> sv/xcpf_frame_ctrl.sv
// Frame state tracker: holds open flag, remaining count and running XOR,
// and builds the byte burst for each request. Depends on xcpf_pkg.
`timescale 1ns / 1ps

module xcpf_frame_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    cmd,
   input  logic [xcpf_pkg::ByteW-1:0] body_length,
   input  logic [xcpf_pkg::ByteW-1:0] message_type,
   input  logic [xcpf_pkg::ByteW-1:0] body_byte,
   input  logic [xcpf_pkg::ByteW-1:0] start_byte,
   input  logic [xcpf_pkg::ByteW-1:0] stop_byte,
   output xcpf_pkg::burst_type      burst
);
   import xcpf_pkg::*;

   logic             frame_open_ff, frame_open_in;
   logic [ByteW-1:0] remaining_ff, remaining_in;
   logic [ByteW-1:0] xor_ff, xor_in;
   logic [ByteW-1:0] hdr_xor, body_xor, rem_dec;

   assign hdr_xor  = body_length ^ message_type;
   assign body_xor = xor_ff ^ body_byte;
   assign rem_dec  = remaining_ff - 8'd1;

   // Burst and next state for the request on the input
   always_comb begin
      burst         = '0;
      frame_open_in = frame_open_ff;
      remaining_in  = remaining_ff;
      xor_in        = xor_ff;
      if (cmd == CMD_HEADER) begin
         if (frame_open_ff) begin
            burst.error = 1'b1;
         end else begin
            burst.bytes[0] = start_byte;
            burst.bytes[1] = body_length;
            burst.bytes[2] = message_type;
            burst.bytes[3] = hdr_xor;
            burst.bytes[4] = stop_byte;
            xor_in         = hdr_xor;
            if (body_length == '0) begin
               burst.last_idx = IdxW'(4);
               burst.trailer  = 1'b1;
               frame_open_in  = 1'b0;
               remaining_in   = '0;
            end else begin
               burst.last_idx = IdxW'(2);
               frame_open_in  = 1'b1;
               remaining_in   = body_length;
            end
         end
      end else begin
         if (!frame_open_ff) begin
            burst.error = 1'b1;
         end else begin
            burst.bytes[0] = body_byte;
            burst.bytes[1] = body_xor;
            burst.bytes[2] = stop_byte;
            xor_in         = body_xor;
            remaining_in   = rem_dec;
            if (rem_dec == '0) begin
               burst.last_idx = IdxW'(2);
               burst.trailer  = 1'b1;
               frame_open_in  = 1'b0;
            end
         end
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= '0;
         xor_ff        <= '0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         remaining_ff  <= remaining_in;
         xor_ff        <= xor_in;
      end
   end

endmodule

>>> sv/xcpf_serializer.sv
// Burst buffer and output register: sends a stored burst one byte per
// cycle on the result channel unless rsp_stall holds the output register. Depends on xcpf_pkg.
`timescale 1ns / 1ps

module xcpf_serializer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  xcpf_pkg::burst_type        burst,
   output logic                       ready,
   output logic                       busy,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [xcpf_pkg::ByteW-1:0] rsp_tx_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_done,
   output logic                       rsp_sequence_error
);
   import xcpf_pkg::*;

   burst_type       buf_ff;
   logic            busy_ff, busy_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            valid_ff, valid_in;
   logic [ByteW-1:0] byte_ff;
   logic            last_ff, done_ff, err_ff;
   logic            out_free, move, last_move;

   // Move a byte whenever the output register is empty or draining
   assign out_free  = !valid_ff || !rsp_stall;
   assign move      = busy_ff && out_free;
   assign last_move = move && (idx_ff == buf_ff.last_idx);
   assign ready     = !busy_ff || last_move;

   always_comb begin
      busy_in  = load ? 1'b1 : (last_move ? 1'b0 : busy_ff);
      idx_in   = load ? '0 : (move ? idx_ff + IdxW'(1) : idx_ff);
      valid_in = move ? 1'b1 : (out_free ? 1'b0 : valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= burst;
      end
      if (move) begin
         byte_ff <= buf_ff.bytes[idx_ff];
         last_ff <= (idx_ff == buf_ff.last_idx);
         done_ff <= (idx_ff == buf_ff.last_idx) && buf_ff.trailer;
         err_ff  <= buf_ff.error;
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_tx_byte        = byte_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_sequence_error = err_ff;

endmodule

>>> tb/tb_xor_checksum_packet_framer_unit.sv
// Self-checking testbench for xor_checksum_packet_framer_unit: directed table, then
// random well-formed frames mixed with out-of-order requests. Depends on xcpf_pkg.
`timescale 1ns / 1ps

module tb_xor_checksum_packet_framer_unit;
   import xcpf_pkg::*;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      ROW_CHECK_MODEL,
      ROW_CHECK_ERROR,
      ROW_CHECK_EMPTY
   } row_check_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [ByteW-1:0] body_length;
      logic [ByteW-1:0] message_type;
      logic [ByteW-1:0] body_byte;
      row_check_type    check;
   } frame_row_type;

   typedef struct packed {
      logic [ByteW-1:0] tx_byte;
      logic             last_of_run;
      logic             frame_done;
      logic             sequence_error;
   } tx_result_type;

   localparam int unsigned NumRows = 17;

   // Directed requests; markers are at their reset values here.
   localparam frame_row_type DirectedRows [NumRows] = '{
      '{CMD_BODY,   8'hAA, 8'h55, 8'h77, ROW_CHECK_ERROR},  // body, no frame open
      '{CMD_HEADER, 8'h00, 8'hFF, 8'h00, ROW_CHECK_EMPTY},  // empty body
      '{CMD_HEADER, 8'h00, 8'h00, 8'hFF, ROW_CHECK_EMPTY},
      '{CMD_HEADER, 8'h01, 8'hA5, 8'h3C, ROW_CHECK_MODEL},
      '{CMD_HEADER, 8'h00, 8'h11, 8'h00, ROW_CHECK_ERROR},  // header while open
      '{CMD_BODY,   8'hFF, 8'hFF, 8'hFF, ROW_CHECK_MODEL},  // last body byte
      '{CMD_BODY,   8'h00, 8'h00, 8'h00, ROW_CHECK_ERROR},
      '{CMD_HEADER, 8'h03, 8'h5A, 8'hFF, ROW_CHECK_MODEL},
      '{CMD_BODY,   8'hFF, 8'hFF, 8'h00, ROW_CHECK_MODEL},
      '{CMD_HEADER, 8'hFF, 8'hFF, 8'hFF, ROW_CHECK_ERROR},
      '{CMD_BODY,   8'h00, 8'h00, 8'h81, ROW_CHECK_MODEL},
      '{CMD_BODY,   8'h00, 8'h00, 8'hFF, ROW_CHECK_MODEL},
      '{CMD_HEADER, 8'h02, 8'h00, 8'h00, ROW_CHECK_MODEL},
      '{CMD_BODY,   8'h00, 8'h00, 8'h55, ROW_CHECK_MODEL},
      '{CMD_BODY,   8'h00, 8'h00, 8'hAA, ROW_CHECK_MODEL},
      '{CMD_HEADER, 8'h00, 8'h80, 8'h00, ROW_CHECK_EMPTY},
      '{CMD_BODY,   8'h00, 8'h00, 8'h01, ROW_CHECK_ERROR}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_cmd = 1'b0;
   logic [ByteW-1:0] req_body_length = '0;
   logic [ByteW-1:0] req_message_type = '0;
   logic [ByteW-1:0] req_body_byte = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [ByteW-1:0] rsp_tx_byte;
   logic             rsp_last_of_run;
   logic             rsp_frame_done;
   logic             rsp_sequence_error;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [DataW-1:0] csr_pwdata = '0;
   logic [DataW-1:0] csr_prdata;
   logic             csr_pready;

   // Framer mirror: markers and frame state.
   logic [ByteW-1:0] start_marker = StartByteReset;
   logic [ByteW-1:0] stop_marker  = StopByteReset;
   logic             frame_is_open = 1'b0;
   logic [ByteW-1:0] body_left = '0;
   logic [ByteW-1:0] checksum_acc = '0;

   tx_result_type tx_expected_q[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int bytes_checked = 0;
   int frames_closed = 0;
   int order_errors = 0;

   xor_checksum_packet_framer_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_body_length    (req_body_length),
      .req_message_type   (req_message_type),
      .req_body_byte      (req_body_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_sequence_error (rsp_sequence_error),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #1 clock = ~clock;

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic void push_byte(input logic [ByteW-1:0] value, input logic last,
                                     input logic done, input logic err, input bit record);
      tx_result_type r;
      r = '{value, last, done, err};
      if (record) tx_expected_q.push_back(r);
   endfunction

   function automatic void emit_trailer(input bit record);
      push_byte(checksum_acc, 1'b0, 1'b0, 1'b0, record);
      push_byte(stop_marker, 1'b1, 1'b1, 1'b0, record);
      frame_is_open = 1'b0;
      body_left = '0;
   endfunction

   // Frame builder: advances the mirror and queues the bytes one request yields.
   function automatic void frame_predict(input cmd_type cmd, input logic [ByteW-1:0] len,
                                         input logic [ByteW-1:0] typ,
                                         input logic [ByteW-1:0] body, input bit record);
      if (cmd == CMD_HEADER && frame_is_open) begin
         push_byte('0, 1'b1, 1'b0, 1'b1, record);
      end else if (cmd == CMD_HEADER) begin
         checksum_acc = len ^ typ;
         body_left = len;
         frame_is_open = 1'b1;
         push_byte(start_marker, 1'b0, 1'b0, 1'b0, record);
         push_byte(len, 1'b0, 1'b0, 1'b0, record);
         if (len == '0) begin
            push_byte(typ, 1'b0, 1'b0, 1'b0, record);
            emit_trailer(record);
         end else begin
            push_byte(typ, 1'b1, 1'b0, 1'b0, record);
         end
      end else if (!frame_is_open) begin
         push_byte('0, 1'b1, 1'b0, 1'b1, record);
      end else begin
         checksum_acc = checksum_acc ^ body;
         body_left = body_left - 8'd1;
         if (body_left == '0) begin
            push_byte(body, 1'b0, 1'b0, 1'b0, record);
            emit_trailer(record);
         end else begin
            push_byte(body, 1'b1, 1'b0, 1'b0, record);
         end
      end
   endfunction

   // Result monitor
   always @(posedge clock) begin
      tx_result_type got;
      tx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_tx_byte, rsp_last_of_run, rsp_frame_done, rsp_sequence_error};
         bytes_checked++;
         if (got.frame_done) frames_closed++;
         if (got.sequence_error) order_errors++;
         if (tx_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result byte %h last %b done %b err %b", $realtime,
                        got.tx_byte, got.last_of_run, got.frame_done, got.sequence_error);
         end else begin
            want = tx_expected_q.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch exp byte %h last %b done %b err %b,",
                           $realtime, want.tx_byte, want.last_of_run, want.frame_done,
                           want.sequence_error);
                  $display("   got byte %h last %b done %b err %b",
                           got.tx_byte, got.last_of_run, got.frame_done,
                           got.sequence_error);
               end
            end
         end
      end
   end

   // One request: optional idle gap, then hold until taken.
   task automatic send_request(input cmd_type cmd, input logic [ByteW-1:0] len,
                               input logic [ByteW-1:0] typ, input logic [ByteW-1:0] body,
                               input row_check_type check);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_body_length  <= len;
      req_message_type <= typ;
      req_body_byte    <= body;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      case (check)
         ROW_CHECK_ERROR: begin
            push_byte('0, 1'b1, 1'b0, 1'b1, 1'b1);
            frame_predict(cmd, len, typ, body, 1'b0);
         end
         ROW_CHECK_EMPTY: begin
            push_byte(StartByteReset, 1'b0, 1'b0, 1'b0, 1'b1);
            push_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            push_byte(typ, 1'b0, 1'b0, 1'b0, 1'b1);
            push_byte(typ, 1'b0, 1'b0, 1'b0, 1'b1);
            push_byte(StopByteReset, 1'b1, 1'b1, 1'b0, 1'b1);
            frame_predict(cmd, len, typ, body, 1'b0);
         end
         default: frame_predict(cmd, len, typ, body, 1'b1);
      endcase
   endtask

   // Register port transfer: setup then access.
   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= AddrW'(int'(idx) * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write both markers (junk in the upper bits), then read them back.
   task automatic set_markers(input logic [ByteW-1:0] start_val, input logic [ByteW-1:0] stop_val);
      logic [DataW-1:0] rd;
      csr_access(REG_START_BYTE, 1'b1, {24'($urandom_range(32'hFF_FFFF)), start_val}, rd);
      start_marker = start_val;
      csr_access(REG_STOP_BYTE, 1'b1, {24'($urandom_range(32'hFF_FFFF)), stop_val}, rd);
      stop_marker = stop_val;
      csr_access(REG_START_BYTE, 1'b0, '0, rd);
      if (rd[ByteW-1:0] != start_marker) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("start_byte readback exp %h got %h", start_marker, rd[ByteW-1:0]);
      end
      csr_access(REG_STOP_BYTE, 1'b0, '0, rd);
      if (rd[ByteW-1:0] != stop_marker) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("stop_byte readback exp %h got %h", stop_marker, rd[ByteW-1:0]);
      end
   endtask

   task automatic wait_drained();
      while (tx_expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Random traffic: mostly whole frames, some out-of-order requests.
   task automatic run_random(input int n_items, input bit long_frame);
      int sent;
      int pick;
      logic [ByteW-1:0] len;
      sent = 0;
      while (sent < n_items || frame_is_open) begin
         pick = $urandom_range(99);
         if (!frame_is_open && pick < 8) begin
            send_request(CMD_BODY, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                         ROW_CHECK_MODEL);
         end else if (!frame_is_open) begin
            if (long_frame) len = 8'hFF;
            else if ($urandom_range(99) < 3) len = ByteW'($urandom_range(40, 8));
            else len = ByteW'($urandom_range(7, 0));
            long_frame = 1'b0;
            send_request(CMD_HEADER, len, ByteW'($urandom), ByteW'($urandom), ROW_CHECK_MODEL);
         end else if (pick < 5) begin
            send_request(CMD_HEADER, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                         ROW_CHECK_MODEL);
         end else begin
            send_request(CMD_BODY, ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                         ROW_CHECK_MODEL);
         end
         sent++;
      end
   endtask

   task automatic run_phase(input logic [ByteW-1:0] start_val, input logic [ByteW-1:0] stop_val,
                            input int idle_pct, input int stall_pct, input bit long_frame);
      req_valid <= 1'b0;
      wait_drained();
      set_markers(start_val, stop_val);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      run_random(65, long_frame);
   endtask

   // Main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, markers at reset values, no idling
      for (int i = 0; i < NumRows; i++)
         send_request(DirectedRows[i].cmd, DirectedRows[i].body_length,
                      DirectedRows[i].message_type, DirectedRows[i].body_byte,
                      DirectedRows[i].check);

      run_phase(8'h00, 8'hFF, 0, 0, 1'b1);
      run_phase(8'hFF, 8'h00, 79, 0, 1'b0);
      run_phase(ByteW'($urandom), ByteW'($urandom), 0, 79, 1'b0);
      run_phase(8'h7E, 8'h7E, 9, 9, 1'b0);

      req_valid <= 1'b0;
      wait_drained();
      if (tx_expected_q.size() != 0) mismatch_count++;

      $display("Sent %0d requests over five marker settings and four idle patterns;",
               requests_sent);
      $display("checked %0d result bytes, %0d frames closed, %0d out-of-order requests.",
               bytes_checked, frames_closed, order_errors);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("Timeout with %0d results still expected", tx_expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
